// File: design/obbsat_pkg.sv
// Shared types, constants and helper functions for the box pair separating axis test.
// Used by the top level, the multiply-accumulate unit, the sequencer and the checker; depends on nothing else.
package obbsat_pkg;

   localparam int DATA_W        = 32;
   localparam int NUM_DIMS      = 3;
   localparam int NUM_SLOTS     = 6;
   localparam int NUM_BOX_AXES  = 6;
   localparam int NUM_ENTRIES   = 2 * NUM_SLOTS;
   localparam int ADDR_W        = $clog2(NUM_ENTRIES);
   localparam int ENTRY_W       = NUM_DIMS * DATA_W;
   localparam int FRAC_BITS_DEF = 16;

   // limb arithmetic of the shared multiplier
   localparam int LIMB_W    = 32;
   localparam int PP_W      = 2 * LIMB_W;
   localparam int OPA_LIMBS = 4;
   localparam int OPB_LIMBS = 3;
   localparam int OPA_W     = OPA_LIMBS * LIMB_W;
   localparam int OPB_W     = OPB_LIMBS * LIMB_W;

   // exact widths of the intermediate values
   localparam int D_W   = 66;   // center distance component
   localparam int L_W   = 65;   // cross product axis component
   localparam int ACC_W = 136;  // projections and radius sums

   localparam logic [2:0] SLOT_TRANS  = 3'd3;
   localparam logic [2:0] SLOT_CENTER = 3'd4;
   localparam logic [2:0] SLOT_HALF   = 3'd5;

   localparam logic [3:0] LAST_AXIS = 4'd14;
   localparam logic [3:0] NO_AXIS   = 4'd15;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_RUN  = 1'b1
   } func_type;

   typedef struct packed {
      func_type           func;
      logic               box_sel;
      logic [2:0]         slot;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } req_type;

   typedef struct packed {
      logic       overlap;
      logic [3:0] separating_axis;
   } rsp_type;

   typedef enum logic [1:0] {
      A_RAM,
      A_DIST,
      A_ACC
   } a_src_type;

   typedef enum logic [1:0] {
      B_RAM,
      B_LVEC,
      B_ONE,
      B_SCALE
   } b_src_type;

   typedef enum logic [1:0] {
      P_NONE,
      P_DIST,
      P_LVEC
   } post_type;

   // one multiply-accumulate step handed from the sequencer to the unit
   typedef struct packed {
      a_src_type         a_src;
      logic [ADDR_W-1:0] a_addr;
      logic [1:0]        a_comp;
      b_src_type         b_src;
      logic [ADDR_W-1:0] b_addr;
      logic [1:0]        b_comp;
      logic              sub;
      logic              abs_b;
      logic              to_rad;
      logic              clr;
      post_type          post;
      logic [1:0]        post_idx;
   } step_type;

   typedef struct packed {
      logic done;
      logic sep;
   } mac_stat_type;

   typedef enum logic [2:0] {
      M_IDLE,
      M_RDA,
      M_LDA,
      M_LDB,
      M_MUL,
      M_DRAIN,
      M_DONE
   } mac_state_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_POS,
      SQ_LGEN,
      SQ_TDOT,
      SQ_RAD,
      SQ_SDOT,
      SQ_OUT
   } seq_state_type;

   function automatic logic [ADDR_W-1:0] entry_addr(input logic box, input logic [2:0] slot);
      return box ? ADDR_W'(NUM_SLOTS) + ADDR_W'(slot) : ADDR_W'(slot);
   endfunction

   // box axis 0..5 to store entry
   function automatic logic [ADDR_W-1:0] axis_addr(input logic [2:0] j);
      return (j >= 3'd3) ? entry_addr(1'b1, j - 3'd3) : entry_addr(1'b0, j);
   endfunction

   function automatic logic [1:0] axis_dim(input logic [2:0] j);
      logic [2:0] r;
      r = (j >= 3'd3) ? j - 3'd3 : j;
      return r[1:0];
   endfunction

   function automatic logic [1:0] add3(input logic [1:0] c, input logic [1:0] k);
      logic [2:0] s;
      s = {1'b0, c} + {1'b0, k};
      if (s >= 3'd3) begin
         s = s - 3'd3;
      end
      return s[1:0];
   endfunction

   // cross axes 6..14: outer box 0 axis and inner box 1 axis
   function automatic logic [1:0] cross_i(input logic [3:0] n);
      logic [3:0] m;
      m = n - 4'd6;
      return (m >= 4'd6) ? 2'd2 : ((m >= 4'd3) ? 2'd1 : 2'd0);
   endfunction

   function automatic logic [1:0] cross_k(input logic [3:0] n);
      logic [3:0] m;
      m = n - 4'd6;
      if (m >= 4'd6) begin
         m = m - 4'd6;
      end else if (m >= 4'd3) begin
         m = m - 4'd3;
      end
      return m[1:0];
   endfunction

endpackage

// File: design/obb_pair_intersection_test_top.sv
// Top level of the oriented box pair separating axis test.
// Depends on obbsat_pkg, obbsat_ram, obbsat_mac and obbsat_seq.
//
// Usage:
// - req channel (req_valid/req_stall/req_data) takes load and run items. A load
//   writes one vector (axis x/y/z, translation, local center or half sizes) of
//   one box and gives no result; slots 6 and 7 are dropped.
// - A run item tests up to 15 axes with one shared 32x32 limb multiplier and
//   returns one item on rsp: overlap and the index of the first separating axis
//   (15 when none).
// - A run tests the box centers first, then each candidate axis in turn;
//   testing stops at the first separating axis. Each multiply-accumulate
//   step multiplies its operands one limb partial product at a time.
// - req_stall is high while a run is in progress; loads go through at one per
//   cycle when no run is in progress. One run at a time.
// - The result sits in an output register; rsp_stall holds it, and a run that
//   finishes meanwhile waits for the register to free up.
// - Reset (synchronous) clears control state only; box vectors are undefined
//   until loaded.
module obb_pair_intersection_test_top #(
   parameter int FRAC_BITS = obbsat_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  obbsat_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output obbsat_pkg::rsp_type  rsp_data
);
   import obbsat_pkg::*;

   logic req_xfer, start, ram_we, busy, out_free, go, res_valid;
   logic [ADDR_W-1:0] ram_addr, mac_addr;
   logic [ENTRY_W-1:0] ram_rdata;
   step_type step;
   mac_stat_type mac_stat;
   rsp_type res;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign req_stall = busy;
   assign req_xfer  = req_valid && !req_stall;
   assign start     = req_xfer && (req_data.func == FUNC_RUN);
   assign ram_we    = req_xfer && (req_data.func == FUNC_LOAD) &&
                      (req_data.slot < 3'(NUM_SLOTS));
   assign ram_addr  = busy ? mac_addr : entry_addr(req_data.box_sel, req_data.slot);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   obbsat_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_ENTRIES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata ({req_data.vec_z, req_data.vec_y, req_data.vec_x}),
      .rdata (ram_rdata)
   );

   obbsat_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .step      (step),
      .ram_rdata (ram_rdata),
      .ram_addr  (mac_addr),
      .stat      (mac_stat)
   );

   obbsat_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .out_free  (out_free),
      .mac_stat  (mac_stat),
      .go        (go),
      .step      (step),
      .busy      (busy),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/obbsat_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module obbsat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/obbsat_mac.sv
// Shared multiply-accumulate unit: 32x32 limb multiplier, projection and radius
// accumulators, distance and axis registers. Depends on obbsat_pkg.
module obbsat_mac #(
   parameter int FRAC_BITS = obbsat_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  obbsat_pkg::step_type             step,
   input  logic [obbsat_pkg::ENTRY_W-1:0]   ram_rdata,
   output logic [obbsat_pkg::ADDR_W-1:0]    ram_addr,
   output obbsat_pkg::mac_stat_type         stat
);
   import obbsat_pkg::*;

   mac_state_type state_ff, state_in;

   logic [OPA_LIMBS-1:0][LIMB_W-1:0] opa_ff, opa_in;
   logic [OPB_LIMBS-1:0][LIMB_W-1:0] opb_ff, opb_in;
   logic opa_neg_ff, opa_neg_in, opb_neg_ff, opb_neg_in;
   logic [1:0] a_last_ff, a_last_in, b_last_ff, b_last_in;
   logic [1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic [PP_W-1:0] pp_ff, pp_in;
   logic [2:0] sh_ff, sh_in;
   logic ppv_ff, ppv_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] rad_ff, rad_in;
   logic signed [D_W-1:0] d_ff [NUM_DIMS];
   logic signed [D_W-1:0] d_in [NUM_DIMS];
   logic signed [L_W-1:0] l_ff [NUM_DIMS];
   logic signed [L_W-1:0] l_in [NUM_DIMS];

   logic [1:0] word_comp;
   logic signed [DATA_W-1:0] ram_word;
   logic [DATA_W-1:0] ram_mag;
   logic signed [D_W-1:0] d_sel;
   logic [D_W-1:0] d_mag;
   logic signed [L_W-1:0] l_sel;
   logic [L_W-1:0] l_mag;
   logic [ACC_W-1:0] acc_abs;
   logic [ACC_W+PP_W-1:0] pp_ext;
   logic [ACC_W-1:0] pp_shift, add_base, add_out;

   assign word_comp = (state_ff == M_LDB) ? step.b_comp : step.a_comp;
   assign ram_word  = ram_rdata[word_comp*DATA_W +: DATA_W];
   assign ram_mag   = ram_word[DATA_W-1] ? DATA_W'(-ram_word) : DATA_W'(ram_word);
   assign d_sel     = d_ff[step.a_comp];
   assign d_mag     = d_sel[D_W-1] ? D_W'(-d_sel) : D_W'(d_sel);
   assign l_sel     = l_ff[step.b_comp];
   assign l_mag     = l_sel[L_W-1] ? L_W'(-l_sel) : L_W'(l_sel);
   assign acc_abs   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   // partial product placed at its limb offset
   assign pp_ext   = {{ACC_W{1'b0}}, pp_ff} << (sh_ff * LIMB_W);
   assign pp_shift = pp_ext[ACC_W-1:0];
   assign add_base = step.to_rad ? rad_ff : ACC_W'(acc_ff);
   assign add_out  = (opa_neg_ff ^ opb_neg_ff) ? add_base - pp_shift : add_base + pp_shift;

   assign stat.done = (state_ff == M_DONE);
   assign stat.sep  = (acc_abs > rad_ff);

   always_comb begin
      state_in   = state_ff;
      opa_in     = opa_ff;
      opb_in     = opb_ff;
      opa_neg_in = opa_neg_ff;
      opb_neg_in = opb_neg_ff;
      a_last_in  = a_last_ff;
      b_last_in  = b_last_ff;
      ia_in      = ia_ff;
      ib_in      = ib_ff;
      pp_in      = PP_W'(opa_ff[ia_ff]) * PP_W'(opb_ff[ib_ff]);
      sh_in      = sh_ff;
      ppv_in     = 1'b0;
      acc_in     = acc_ff;
      rad_in     = rad_ff;
      d_in       = d_ff;
      l_in       = l_ff;
      ram_addr   = step.a_addr;

      case (state_ff)
         M_IDLE: begin
            if (go) begin
               state_in = M_RDA;
            end
         end
         M_RDA: begin
            state_in = M_LDA;
         end
         M_LDA: begin
            ram_addr = step.b_addr;
            case (step.a_src)
               A_RAM: begin
                  opa_in     = OPA_W'(ram_mag);
                  opa_neg_in = ram_word[DATA_W-1];
                  a_last_in  = 2'd0;
               end
               A_DIST: begin
                  opa_in     = OPA_W'(d_mag);
                  opa_neg_in = d_sel[D_W-1];
                  a_last_in  = 2'd2;
               end
               A_ACC: begin
                  opa_in     = acc_abs[OPA_W-1:0];
                  opa_neg_in = 1'b0;
                  a_last_in  = 2'd3;
               end
               default: begin
                  opa_in     = '0;
                  opa_neg_in = 1'b0;
                  a_last_in  = 2'd0;
               end
            endcase
            if (step.clr) begin
               if (step.to_rad) begin
                  rad_in = '0;
               end else begin
                  acc_in = '0;
               end
            end
            state_in = M_LDB;
         end
         M_LDB: begin
            case (step.b_src)
               B_RAM: begin
                  opb_in     = OPB_W'(ram_mag);
                  opb_neg_in = !step.abs_b && ram_word[DATA_W-1];
                  b_last_in  = 2'd0;
               end
               B_LVEC: begin
                  opb_in     = OPB_W'(l_mag);
                  opb_neg_in = l_sel[L_W-1];
                  b_last_in  = 2'd2;
               end
               B_ONE: begin
                  opb_in     = OPB_W'(1);
                  opb_neg_in = 1'b0;
                  b_last_in  = 2'd0;
               end
               B_SCALE: begin
                  opb_in     = OPB_W'(1) << FRAC_BITS;
                  opb_neg_in = 1'b0;
                  b_last_in  = 2'd0;
               end
               default: begin
                  opb_in     = '0;
                  opb_neg_in = 1'b0;
                  b_last_in  = 2'd0;
               end
            endcase
            if (step.sub) begin
               opb_neg_in = !opb_neg_in;
            end
            ia_in    = 2'd0;
            ib_in    = 2'd0;
            state_in = M_MUL;
         end
         M_MUL: begin
            ppv_in = 1'b1;
            sh_in  = {1'b0, ia_ff} + {1'b0, ib_ff};
            if (ib_ff == b_last_ff) begin
               ib_in = 2'd0;
               if (ia_ff == a_last_ff) begin
                  state_in = M_DRAIN;
               end else begin
                  ia_in = ia_ff + 2'd1;
               end
            end else begin
               ib_in = ib_ff + 2'd1;
            end
         end
         M_DRAIN: begin
            state_in = M_DONE;
         end
         M_DONE: begin
            case (step.post)
               P_DIST:  d_in[step.post_idx] = acc_ff[D_W-1:0];
               P_LVEC:  l_in[step.post_idx] = acc_ff[L_W-1:0];
               default: ;
            endcase
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase

      if (ppv_ff) begin
         if (step.to_rad) begin
            rad_in = add_out;
         end else begin
            acc_in = add_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         ppv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ppv_ff   <= ppv_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      opa_neg_ff <= opa_neg_in;
      opb_neg_ff <= opb_neg_in;
      a_last_ff  <= a_last_in;
      b_last_ff  <= b_last_in;
      ia_ff      <= ia_in;
      ib_ff      <= ib_in;
      pp_ff      <= pp_in;
      sh_ff      <= sh_in;
      acc_ff     <= acc_in;
      rad_ff     <= rad_in;
      d_ff       <= d_in;
      l_ff       <= l_in;
   end

endmodule

// File: design/obbsat_seq.sv
// Sequencer: walks box centers, up to 15 candidate axes and their projections,
// issuing one multiply-accumulate step at a time. Depends on obbsat_pkg.
module obbsat_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      out_free,
   input  obbsat_pkg::mac_stat_type  mac_stat,
   output logic                      go,
   output obbsat_pkg::step_type      step,
   output logic                      busy,
   output logic                      res_valid,
   output obbsat_pkg::rsp_type       res
);
   import obbsat_pkg::*;

   seq_state_type state_ff, state_in;
   logic [3:0] n_ff, n_in;
   logic [2:0] j_ff, j_in;
   logic [1:0] c_ff, c_in, m_ff, m_in;
   logic b_ff, b_in;
   logic [3:0] found_ff, found_in;
   logic [1:0] pc, qc;

   // components of the two cross product terms
   assign pc = (m_ff == 2'd0) ? add3(c_ff, 2'd1) : add3(c_ff, 2'd2);
   assign qc = (m_ff == 2'd0) ? add3(c_ff, 2'd2) : add3(c_ff, 2'd1);

   assign busy                = (state_ff != SQ_IDLE);
   assign res.separating_axis = found_ff;
   assign res.overlap         = (found_ff == NO_AXIS);

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      j_in      = j_ff;
      c_in      = c_ff;
      m_in      = m_ff;
      b_in      = b_ff;
      found_in  = found_ff;
      go        = 1'b0;
      res_valid = 1'b0;
      step      = '0;
      step.post_idx = c_ff;

      case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               state_in = SQ_POS;
               n_in     = 4'd0;
               j_in     = 3'd0;
               c_in     = 2'd0;
               m_in     = 2'd0;
               b_in     = 1'b0;
            end
         end
         SQ_POS: begin
            // world center of box 0 minus that of box 1
            go       = 1'b1;
            step.sub = b_ff;
            step.clr = !b_ff && (m_ff == 2'd0);
            step.post = (b_ff && m_ff == 2'd3) ? P_DIST : P_NONE;
            step.a_src = A_RAM;
            if (m_ff == 2'd0) begin
               step.a_addr = entry_addr(b_ff, SLOT_TRANS);
               step.a_comp = c_ff;
               step.b_src  = B_SCALE;
            end else begin
               step.a_addr = entry_addr(b_ff, SLOT_CENTER);
               step.a_comp = m_ff - 2'd1;
               step.b_src  = B_RAM;
               step.b_addr = entry_addr(b_ff, {1'b0, m_ff - 2'd1});
               step.b_comp = c_ff;
            end
            if (mac_stat.done) begin
               if (m_ff == 2'd3) begin
                  m_in = 2'd0;
                  if (b_ff) begin
                     b_in = 1'b0;
                     if (c_ff == 2'd2) begin
                        c_in     = 2'd0;
                        state_in = SQ_LGEN;
                     end else begin
                        c_in = c_ff + 2'd1;
                     end
                  end else begin
                     b_in = 1'b1;
                  end
               end else begin
                  m_in = m_ff + 2'd1;
               end
            end
         end
         SQ_LGEN: begin
            go = 1'b1;
            step.a_src = A_RAM;
            if (n_ff < 4'(NUM_BOX_AXES)) begin
               step.a_addr = axis_addr(n_ff[2:0]);
               step.a_comp = c_ff;
               step.b_src  = B_ONE;
               step.clr    = 1'b1;
               step.post   = P_LVEC;
               if (mac_stat.done) begin
                  if (c_ff == 2'd2) begin
                     c_in     = 2'd0;
                     j_in     = 3'd0;
                     state_in = SQ_TDOT;
                  end else begin
                     c_in = c_ff + 2'd1;
                  end
               end
            end else begin
               step.a_addr = entry_addr(1'b0, {1'b0, cross_i(n_ff)});
               step.a_comp = pc;
               step.b_src  = B_RAM;
               step.b_addr = entry_addr(1'b1, {1'b0, cross_k(n_ff)});
               step.b_comp = qc;
               step.clr    = (m_ff == 2'd0);
               step.sub    = (m_ff == 2'd1);
               step.post   = (m_ff == 2'd1) ? P_LVEC : P_NONE;
               if (mac_stat.done) begin
                  if (m_ff == 2'd1) begin
                     m_in = 2'd0;
                     if (c_ff == 2'd2) begin
                        c_in     = 2'd0;
                        j_in     = 3'd0;
                        state_in = SQ_TDOT;
                     end else begin
                        c_in = c_ff + 2'd1;
                     end
                  end else begin
                     m_in = 2'd1;
                  end
               end
            end
         end
         SQ_TDOT: begin
            // candidate axis against box axis j
            go          = 1'b1;
            step.a_src  = A_RAM;
            step.a_addr = axis_addr(j_ff);
            step.a_comp = c_ff;
            step.b_src  = B_LVEC;
            step.b_comp = c_ff;
            step.clr    = (c_ff == 2'd0);
            if (mac_stat.done) begin
               if (c_ff == 2'd2) begin
                  c_in     = 2'd0;
                  state_in = SQ_RAD;
               end else begin
                  c_in = c_ff + 2'd1;
               end
            end
         end
         SQ_RAD: begin
            // radius += |half size| * |projection|
            go          = 1'b1;
            step.a_src  = A_ACC;
            step.b_src  = B_RAM;
            step.b_addr = entry_addr(j_ff >= 3'd3, SLOT_HALF);
            step.b_comp = axis_dim(j_ff);
            step.abs_b  = 1'b1;
            step.to_rad = 1'b1;
            step.clr    = (j_ff == 3'd0);
            if (mac_stat.done) begin
               if (j_ff == 3'(NUM_BOX_AXES - 1)) begin
                  j_in     = 3'd0;
                  c_in     = 2'd0;
                  state_in = SQ_SDOT;
               end else begin
                  j_in     = j_ff + 3'd1;
                  state_in = SQ_TDOT;
               end
            end
         end
         SQ_SDOT: begin
            go          = 1'b1;
            step.a_src  = A_DIST;
            step.a_comp = c_ff;
            step.b_src  = B_LVEC;
            step.b_comp = c_ff;
            step.clr    = (c_ff == 2'd0);
            if (mac_stat.done) begin
               if (c_ff == 2'd2) begin
                  c_in = 2'd0;
                  m_in = 2'd0;
                  if (mac_stat.sep) begin
                     found_in = n_ff;
                     state_in = SQ_OUT;
                  end else if (n_ff == LAST_AXIS) begin
                     found_in = NO_AXIS;
                     state_in = SQ_OUT;
                  end else begin
                     n_in     = n_ff + 4'd1;
                     state_in = SQ_LGEN;
                  end
               end else begin
                  c_in = c_ff + 2'd1;
               end
            end
         end
         SQ_OUT: begin
            res_valid = out_free;
            if (out_free) begin
               state_in = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      j_ff     <= j_in;
      c_ff     <= c_in;
      m_ff     <= m_in;
      b_ff     <= b_in;
      found_ff <= found_in;
   end

endmodule

// File: design/obbsat_checker.sv
// Port-level checks for the separating axis test top level, bound to it below.
// Depends on obbsat_pkg.
module obbsat_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input obbsat_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input obbsat_pkg::rsp_type rsp_data
);
   import obbsat_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_overlap_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.overlap == (rsp_data.separating_axis == NO_AXIS)))
      else $error("overlap flag disagrees with axis index");

   // a run transfer makes the block busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.func == FUNC_RUN |=> req_stall)
      else $error("run item did not start a test");

   // results only come out of a run
   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a run in progress");

endmodule

bind obb_pair_intersection_test_top obbsat_checker u_checker (.*);
